/* rtl/cft_pkg.sv */
// ----------------------------------------------------------------------------
// cft_pkg: shared types and constants of the configuration field tokenizer
// Character codes, result kinds, queue sizing and the result request records.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam int MAX_NEST = 255;
  localparam int NEST_W = $clog2(MAX_NEST + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int RES_PER_ITEM = 3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  localparam logic [2:0] KIND_WORD   = 3'd0;
  localparam logic [2:0] KIND_GROUP  = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_SEP    = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;
  localparam logic [2:0] KIND_END    = 3'd5;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic [2:0] kind;
    logic       last;
    logic       new_line;
  } rec_t;

  typedef struct packed {
    logic [15:0] line;
    logic [1:0]  cnt;
    rec_t [RES_PER_ITEM-1:0] recs;
  } bundle_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

/* rtl/cft_front.sv */
// ----------------------------------------------------------------------------
// cft_front: scanner front end
// Accepts one character a cycle unless the queue is full, runs the scan mode
// machine and gives each character's result requests to the queue as a bundle.
// ----------------------------------------------------------------------------
module cft_front import cft_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_eod,
  input  q_stat_t    q_stat,
  output logic       push,
  output bundle_t    push_data
);

  typedef enum logic [7:0] {
    M_SEEK     = 8'b0000_0001,
    M_COMMENT  = 8'b0000_0010,
    M_WORD     = 8'b0000_0100,
    M_GROUP    = 8'b0000_1000,
    M_GCOMMENT = 8'b0001_0000,
    M_GSTRING  = 8'b0010_0000,
    M_STRING   = 8'b0100_0000,
    M_AFTER    = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  pend;
    logic  depth_one;
    logic  held_clr;
    logic  rec_ok;
    rec_t  rec;
  } seek_t;

  function automatic rec_t mk_rec(logic [7:0] b, logic has, logic [2:0] k, logic last,
                                  logic nl);
    rec_t r;
    r.data = b;
    r.has_byte = has;
    r.kind = k;
    r.last = last;
    r.new_line = nl;
    return r;
  endfunction

  function automatic seek_t seek_f(logic [7:0] c, logic z, logic pend);
    seek_t s;
    s.mode = M_SEEK;
    s.pend = pend;
    s.depth_one = 1'b0;
    s.held_clr = 1'b0;
    s.rec_ok = 1'b0;
    s.rec = '0;
    priority if (z) begin
      s.rec_ok = 1'b1;
      s.rec = mk_rec(CH_NUL, 1'b0, KIND_END, 1'b1, pend);
      s.pend = 1'b0;
      s.held_clr = 1'b1;
    end else if (c == CH_SP || c == CH_TAB) begin
      s.mode = M_SEEK;
    end else if (c == CH_LF) begin
      s.pend = 1'b1;
    end else if (c == CH_SEMI) begin
      s.mode = M_COMMENT;
    end else if (c == CH_COLON) begin
      s.rec_ok = 1'b1;
      s.rec = mk_rec(CH_NUL, 1'b0, KIND_SEP, 1'b1, pend);
      s.pend = 1'b0;
      s.held_clr = 1'b1;
    end else if (c == CH_LPAR) begin
      s.mode = M_GROUP;
      s.depth_one = 1'b1;
    end else if (c == CH_QUOTE) begin
      s.mode = M_STRING;
      s.held_clr = 1'b1;
    end else begin
      s.mode = M_WORD;
      s.rec_ok = 1'b1;
      s.rec = mk_rec(c, 1'b1, KIND_WORD, 1'b0, pend);
    end
    return s;
  endfunction

  mode_t             mode_r, mode_nxt;
  logic [NEST_W-1:0] depth_r, depth_nxt, depth_dec;
  logic              prev_bs_r, prev_bs_nxt;
  logic              held_r, held_nxt;
  logic              pend_r, pend_nxt;
  logic [15:0]       line_r, line_nxt;

  logic [7:0] c;
  logic       z;
  logic       do_sk;
  logic       sk_pend;
  seek_t      sk;
  rec_t [RES_PER_ITEM-1:0] recs;
  logic [1:0] cnt;
  logic       accept;

  assign in_ready = !q_stat.full;
  assign accept = in_valid && in_ready;

  always_comb begin
    z = in_eod || (in_byte == CH_NUL);
    c = z ? CH_NUL : in_byte;
    if (c == CH_CR) begin
      c = CH_SP;
    end
    line_nxt = (c == CH_LF && line_r != LINE_MAX) ? line_r + 16'd1 : line_r;
    depth_dec = (depth_r != '0) ? depth_r - NEST_W'(1) : depth_r;

    mode_nxt = mode_r;
    depth_nxt = depth_r;
    prev_bs_nxt = prev_bs_r;
    held_nxt = held_r;
    pend_nxt = pend_r;
    recs = '0;
    cnt = 2'd0;
    do_sk = 1'b0;
    sk_pend = 1'b0;

    unique case (mode_r)
      M_SEEK: begin
        do_sk = 1'b1;
        sk_pend = pend_r;
      end
      M_COMMENT: begin
        if (z) begin
          do_sk = 1'b1;
          sk_pend = 1'b1;
        end else if (c == CH_LF) begin
          pend_nxt = 1'b1;
          mode_nxt = M_SEEK;
        end
      end
      M_WORD: begin
        if (z || c == CH_SP || c == CH_TAB || c == CH_LF) begin
          recs[0] = mk_rec(CH_NUL, 1'b0, KIND_WORD, 1'b1, pend_r);
          cnt = 2'd1;
          pend_nxt = 1'b0;
          held_nxt = 1'b0;
          mode_nxt = M_SEEK;
          do_sk = z || (c == CH_LF);
        end else begin
          recs[0] = mk_rec(c, 1'b1, KIND_WORD, 1'b0, pend_r);
          cnt = 2'd1;
        end
      end
      M_GROUP: begin
        priority if (z) begin
          recs[0] = mk_rec(CH_NUL, 1'b0, KIND_ERROR, 1'b1, pend_r);
          cnt = 2'd1;
          do_sk = 1'b1;
        end else if (c == CH_LPAR) begin
          if (depth_r >= NEST_W'(MAX_NEST)) begin
            recs[0] = mk_rec(CH_NUL, 1'b0, KIND_ERROR, 1'b1, pend_r);
            cnt = 2'd1;
            pend_nxt = 1'b0;
            held_nxt = 1'b0;
            mode_nxt = M_SEEK;
          end else begin
            depth_nxt = depth_r + NEST_W'(1);
            recs[0] = mk_rec(c, 1'b1, KIND_GROUP, 1'b0, pend_r);
            cnt = 2'd1;
          end
        end else if (c == CH_RPAR) begin
          depth_nxt = depth_dec;
          cnt = 2'd1;
          if (depth_dec == '0) begin
            recs[0] = mk_rec(CH_NUL, 1'b0, KIND_GROUP, 1'b1, pend_r);
            pend_nxt = 1'b0;
            held_nxt = 1'b0;
            mode_nxt = M_SEEK;
          end else begin
            recs[0] = mk_rec(c, 1'b1, KIND_GROUP, 1'b0, pend_r);
          end
        end else if (c == CH_SEMI) begin
          mode_nxt = M_GCOMMENT;
        end else begin
          if (c == CH_QUOTE) begin
            mode_nxt = M_GSTRING;
            prev_bs_nxt = 1'b0;
          end
          recs[0] = mk_rec(c, 1'b1, KIND_GROUP, 1'b0, pend_r);
          cnt = 2'd1;
        end
      end
      M_GCOMMENT: begin
        if (z) begin
          recs[0] = mk_rec(CH_LF, 1'b1, KIND_GROUP, 1'b0, pend_r);
          recs[1] = mk_rec(CH_NUL, 1'b0, KIND_ERROR, 1'b1, pend_r);
          cnt = 2'd2;
          do_sk = 1'b1;
        end else if (c == CH_LF) begin
          mode_nxt = M_GROUP;
          recs[0] = mk_rec(CH_LF, 1'b1, KIND_GROUP, 1'b0, pend_r);
          cnt = 2'd1;
        end
      end
      M_GSTRING: begin
        if (z || c == CH_LF) begin
          recs[0] = mk_rec(CH_NUL, 1'b0, KIND_ERROR, 1'b1, pend_r);
          cnt = 2'd1;
          pend_nxt = 1'b0;
          held_nxt = 1'b0;
          mode_nxt = M_SEEK;
          do_sk = z;
        end else begin
          if (c == CH_QUOTE && !prev_bs_r) begin
            mode_nxt = M_GROUP;
          end
          prev_bs_nxt = (c == CH_BSL);
          recs[0] = mk_rec(c, 1'b1, KIND_GROUP, 1'b0, pend_r);
          cnt = 2'd1;
        end
      end
      M_STRING: begin
        priority if (z || c == CH_LF) begin
          recs[0] = mk_rec(CH_NUL, 1'b0, KIND_ERROR, 1'b1, pend_r);
          cnt = 2'd1;
          pend_nxt = 1'b0;
          held_nxt = 1'b0;
          mode_nxt = M_SEEK;
          do_sk = z;
        end else if (held_r) begin
          if (c == CH_QUOTE || c == CH_N) begin
            held_nxt = 1'b0;
            recs[0] = mk_rec((c == CH_N) ? CH_CR : c, 1'b1, KIND_STRING, 1'b0, pend_r);
            cnt = 2'd1;
          end else begin
            recs[0] = mk_rec(CH_BSL, 1'b1, KIND_STRING, 1'b0, pend_r);
            cnt = 2'd1;
            if (c != CH_BSL) begin
              held_nxt = 1'b0;
              recs[1] = mk_rec(c, 1'b1, KIND_STRING, 1'b0, pend_r);
              cnt = 2'd2;
            end
          end
        end else if (c == CH_QUOTE) begin
          mode_nxt = M_AFTER;
        end else if (c == CH_BSL) begin
          held_nxt = 1'b1;
        end else begin
          recs[0] = mk_rec(c, 1'b1, KIND_STRING, 1'b0, pend_r);
          cnt = 2'd1;
        end
      end
      M_AFTER: begin
        if (!z && (c == CH_SP || c == CH_TAB || c == CH_LF)) begin
          mode_nxt = M_AFTER;
        end else if (!z && c == CH_QUOTE) begin
          mode_nxt = M_STRING;
          held_nxt = 1'b0;
        end else begin
          recs[0] = mk_rec(CH_NUL, 1'b0, KIND_STRING, 1'b1, pend_r);
          cnt = 2'd1;
          pend_nxt = 1'b0;
          held_nxt = 1'b0;
          mode_nxt = M_SEEK;
          do_sk = 1'b1;
        end
      end
      default: begin
        do_sk = 1'b1;
        sk_pend = pend_r;
      end
    endcase

    sk = seek_f(c, z, sk_pend);
    if (do_sk) begin
      mode_nxt = sk.mode;
      pend_nxt = sk.pend;
      if (sk.depth_one) begin
        depth_nxt = NEST_W'(1);
      end
      if (sk.held_clr) begin
        held_nxt = 1'b0;
      end
      if (sk.rec_ok) begin
        recs[cnt] = sk.rec;
        cnt = cnt + 2'd1;
      end
    end
  end

  assign push = accept && (cnt != 2'd0);
  assign push_data.line = line_nxt;
  assign push_data.cnt = cnt;
  assign push_data.recs = recs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_SEEK;
      depth_r <= '0;
      prev_bs_r <= 1'b0;
      held_r <= 1'b0;
      pend_r <= 1'b0;
      line_r <= 16'd1;
    end else if (accept) begin
      mode_r <= mode_nxt;
      depth_r <= depth_nxt;
      prev_bs_r <= prev_bs_nxt;
      held_r <= held_nxt;
      pend_r <= pend_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

/* rtl/cft_queue.sv */
// ----------------------------------------------------------------------------
// cft_queue: request queue between scanner and emitter
// A short register queue of result bundles; head is read at the read pointer.
// ----------------------------------------------------------------------------
module cft_queue import cft_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output q_stat_t q_stat
);

  bundle_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  assign head = mem_r[rd_r];
  assign q_stat.full = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.count = cnt_r;

endmodule

/* rtl/cft_back.sv */
// ----------------------------------------------------------------------------
// cft_back: result emitter
// Takes the bundle at the queue head apart into single results, one a cycle
// while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module cft_back import cft_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  bundle_t     head,
  input  q_stat_t     q_stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output rec_t        out_rec,
  output logic [15:0] out_line
);

  logic        valid_r, valid_nxt;
  logic [1:0]  sub_r, sub_nxt;
  rec_t        rec_r;
  logic [15:0] line_r;
  logic        take;
  logic        last_sub;

  assign take = (!valid_r || out_ready) && !q_stat.empty;
  assign last_sub = (sub_r == head.cnt - 2'd1);
  assign pop = take && last_sub;

  always_comb begin
    valid_nxt = valid_r;
    sub_nxt = sub_r;
    if (take) begin
      valid_nxt = 1'b1;
      sub_nxt = last_sub ? 2'd0 : sub_r + 2'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      sub_r <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rec_r <= head.recs[sub_r];
      line_r <= head.line;
    end
  end

  assign out_valid = valid_r;
  assign out_rec = rec_r;
  assign out_line = line_r;

endmodule

/* rtl/config_field_tokenizer.sv */
// ----------------------------------------------------------------------------
// config_field_tokenizer: configuration text field tokenizer
// A result is registered in the queue and then in the output register.
// Throughput: one character per cycle; results leave one per cycle while
// out_tready is high; a character with two or three results holds the emitter.
// The four-entry bundle queue absorbs bursts; input stalls only when it fills.
// Reset: synchronous, active low; scanner seeks, line count is one.
// ----------------------------------------------------------------------------
module config_field_tokenizer import cft_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] end_of_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [8] new_line_before,
                                  // [24:9] line_number, rest zero
  output logic [3:0]  out_tuser,  // [0] has_byte, [3:1] field_kind
  output logic        out_tlast   // field_end
);

  q_stat_t     q_stat;
  logic        push;
  bundle_t     push_data;
  logic        pop;
  bundle_t     head;
  rec_t        out_rec;
  logic [15:0] out_line;

  cft_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_eod    (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  cft_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  cft_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rec   (out_rec),
    .out_line  (out_line)
  );

  assign out_tdata = {7'd0, out_line, out_rec.new_line, out_rec.data};
  assign out_tuser = {out_rec.kind, out_rec.has_byte};
  assign out_tlast = out_rec.last;

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_tready)
    else $error("input request taken while queue full");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> q_stat.count == $past(q_stat.count) + QCNT_W'(1))
    else $error("queue count did not follow a push");

  a_marker_results: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[3:1] == KIND_SEP || out_tuser[3:1] == KIND_ERROR ||
                   out_tuser[3:1] == KIND_END) |-> out_tlast && !out_tuser[0])
    else $error("separator, error or end result carries a byte");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[24:9] != 16'd0)
    else $error("line number is zero");

endmodule
